// ----- rtl/grid_ten_minute_overvolt_guard_top_macros.svh -----
// Assertion macros for the overvoltage guard.
// Depends on clk and arst_n in the module that includes this file.
`ifndef GRID_TEN_MINUTE_OVERVOLT_GUARD_TOP_MACROS_SVH
`define GRID_TEN_MINUTE_OVERVOLT_GUARD_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define GTMOG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define GTMOG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gtmog_pkg.sv -----
// Shared types and constants of the ten-minute overvoltage guard.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package gtmog_pkg;

	localparam int unsigned DEF_RING_SLOTS = 16;
	localparam int unsigned DEF_PHASES     = 3;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned BLK_CNT_W = 16;
	localparam int unsigned PH_W      = 2;
	localparam int unsigned APB_AW    = 4;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned DIV_CNT_W = 5;

	typedef enum logic [1:0] {
		REG_LIMIT   = 2'd0,
		REG_PHASES  = 2'd1,
		REG_SPB     = 2'd2,
		REG_NOMINAL = 2'd3
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0]  RST_LIMIT   = 16'd2530;
	localparam logic [PH_W-1:0]      RST_PHASES  = 2'd3;
	localparam logic [BLK_CNT_W-1:0] RST_SPB     = 16'd1500;
	localparam logic [SAMPLE_W-1:0]  RST_NOMINAL = 16'd2300;

endpackage

// ----- rtl/grid_ten_minute_overvolt_guard_top.sv -----
// Ten-minute moving-average overvoltage guard, top level.
// Depends on gtmog_pkg and grid_ten_minute_overvolt_guard_top_macros.svh.
`timescale 1ns / 1ps

// The guard sums one voltage sample per phase for samples_per_block items, echoing
// fault_in, and on the following item turns each phase sum into a block average,
// stores it in a RING_SLOTS-deep ring per phase and flags a fault when any ring mean
// exceeds overvolt_limit; an active fault whose new averages are all within the limit
// clears every ring to nominal_volt. An ordinary item passes one phase per cycle through
// the shared adder. A boundary item runs, for each phase in use, the 32-step restoring
// divider and the one-read-per-cycle sweep of the ring memory. in_ready is high only
// while the block is idle; a finished result waits in the output register, so a new
// item is taken before it is collected. Ring clearing is done with per-entry valid
// bits, so no clearing pass runs after reset.
module grid_ten_minute_overvolt_guard_top
	import gtmog_pkg::*;
#(
	parameter int unsigned RING_SLOTS = DEF_RING_SLOTS,
	parameter int unsigned PHASES     = DEF_PHASES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] volt_r,
	input  logic [SAMPLE_W-1:0] volt_s,
	input  logic [SAMPLE_W-1:0] volt_t,
	input  logic                fault_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                fault_out
);

	localparam int unsigned SLOT_W    = $clog2(RING_SLOTS);
	localparam int unsigned RD_W      = $clog2(RING_SLOTS + 1);
	localparam int unsigned ACC_W     = SAMPLE_W + $clog2(RING_SLOTS);
	localparam int unsigned MEM_DEPTH = PHASES * RING_SLOTS;
	localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
	localparam int unsigned PIDX_W    = (PHASES > 1) ? $clog2(PHASES) : 1;

	localparam logic [RD_W-1:0]   RD_N       = RD_W'(RING_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RING_SLOTS - 1);
	localparam logic [ACC_W-1:0]  SLOTS_ACC  = ACC_W'(RING_SLOTS);
	localparam logic [ACC_W-1:0]  ROUND_ACC  = ACC_W'(RING_SLOTS - 1);
	localparam logic [MEM_AW-1:0] SLOTS_ADDR = MEM_AW'(RING_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_DLD,
		S_DIV,
		S_WR,
		S_SUM,
		S_FIN,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [SAMPLE_W-1:0]  limit_q;
	logic [PH_W-1:0]      phases_in_use_q;
	logic [BLK_CNT_W-1:0] spb_q;
	logic [SAMPLE_W-1:0]  nominal_q;
	logic [SAMPLE_W-1:0]  clr_nom_q;
	logic [ACC_W-1:0]     thr_q;

	// item and block state
	logic [SAMPLE_W-1:0]  volt_r_q, volt_s_q, volt_t_q;
	logic                 fault_q;
	logic [PH_W-1:0]      nph_q;
	logic [PH_W-1:0]      p_q;
	logic [PH_W-1:0]      ok_cnt_q;
	logic                 over_q;
	logic                 res_q;
	logic [SUM_W-1:0]     sums_q [PHASES];
	logic [BLK_CNT_W-1:0] count_q;
	logic [SLOT_W-1:0]    slot_q;

	// divider
	logic [SAMPLE_W-1:0]  rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// ring sweep
	logic [ACC_W-1:0]     acc_q;
	logic [RD_W-1:0]      rd_idx_q;
	logic                 rd_live_q;
	logic [SAMPLE_W-1:0]  ring_mem [MEM_DEPTH];
	logic [SAMPLE_W-1:0]  ring_rd_q;
	logic                 vld_rd_q;
	logic [MEM_DEPTH-1:0] valid_q;

	logic                 out_valid_q;
	logic                 fault_out_q;

	logic                 cfg_we;
	logic [PH_W-1:0]      nph_now;
	logic [PIDX_W-1:0]    pidx;
	logic [SAMPLE_W-1:0]  volt_sel;
	logic [SUM_W-1:0]     add_a, add_b, add_sum;
	logic [SAMPLE_W:0]    rem_shift, rem_diff;
	logic                 rem_ge;
	logic [SAMPLE_W-1:0]  avg;
	logic [SAMPLE_W-1:0]  ring_val;
	logic [MEM_AW-1:0]    base_addr, wr_addr, rd_addr;
	logic                 clear_cond;

	assign pready    = 1'b1;
	assign cfg_we    = psel & penable & pwrite;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign fault_out = fault_out_q;

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_LIMIT:   prdata = APB_DW'(limit_q);
			REG_PHASES:  prdata = APB_DW'(phases_in_use_q);
			REG_SPB:     prdata = APB_DW'(spb_q);
			REG_NOMINAL: prdata = APB_DW'(nominal_q);
			default:     prdata = '0;
		endcase
	end

	assign nph_now = (phases_in_use_q > PH_W'(PHASES)) ? PH_W'(PHASES) : phases_in_use_q;
	assign pidx    = p_q[PIDX_W-1:0];

	always_comb begin
		case (p_q)
			2'd0:    volt_sel = volt_r_q;
			2'd1:    volt_sel = volt_s_q;
			default: volt_sel = volt_t_q;
		endcase
	end

	// shared adder: phase accumulation or ring sweep
	assign ring_val = vld_rd_q ? ring_rd_q : clr_nom_q;
	always_comb begin
		if (state_q == S_ACC) begin
			add_a = sums_q[pidx];
			add_b = SUM_W'(volt_sel);
		end else begin
			add_a = SUM_W'(acc_q);
			add_b = SUM_W'(ring_val);
		end
	end
	assign add_sum = add_a + add_b;

	// one restoring step per cycle
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, count_q});
	assign rem_diff  = rem_shift - {1'b0, count_q};
	assign avg       = (count_q == '0) ? '0 : quo_q[SAMPLE_W-1:0];

	assign base_addr = MEM_AW'(pidx) * SLOTS_ADDR;
	assign wr_addr   = base_addr + MEM_AW'(slot_q);
	assign rd_addr   = base_addr + MEM_AW'(rd_idx_q[SLOT_W-1:0]);

	assign clear_cond = (nph_q != '0) && (ok_cnt_q == nph_q);

	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			ring_mem[wr_addr] <= avg;
		end
		ring_rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			limit_q         <= RST_LIMIT;
			phases_in_use_q <= RST_PHASES;
			spb_q           <= RST_SPB;
			nominal_q       <= RST_NOMINAL;
			clr_nom_q       <= RST_NOMINAL;
			thr_q           <= '0;
			volt_r_q        <= '0;
			volt_s_q        <= '0;
			volt_t_q        <= '0;
			fault_q         <= 1'b0;
			nph_q           <= '0;
			p_q             <= '0;
			ok_cnt_q        <= '0;
			over_q          <= 1'b0;
			res_q           <= 1'b0;
			for (int i = 0; i < PHASES; i++) begin
				sums_q[i] <= '0;
			end
			count_q         <= '0;
			slot_q          <= '0;
			rem_q           <= '0;
			quo_q           <= '0;
			div_cnt_q       <= '0;
			acc_q           <= '0;
			rd_idx_q        <= '0;
			rd_live_q       <= 1'b0;
			vld_rd_q        <= 1'b0;
			valid_q         <= '0;
			out_valid_q     <= 1'b0;
			fault_out_q     <= 1'b0;
		end else begin
			// mean > limit  <=>  ring sum > limit * slots + slots - 1
			thr_q     <= limit_q * SLOTS_ACC + ROUND_ACC;
			vld_rd_q  <= valid_q[rd_addr];
			rd_live_q <= (state_q == S_SUM) && (rd_idx_q != RD_N);

			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_LIMIT:   limit_q         <= pwdata[SAMPLE_W-1:0];
					REG_PHASES:  phases_in_use_q <= pwdata[PH_W-1:0];
					REG_SPB:     spb_q           <= pwdata[BLK_CNT_W-1:0];
					REG_NOMINAL: nominal_q       <= pwdata[SAMPLE_W-1:0];
					default:     ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						volt_r_q <= volt_r;
						volt_s_q <= volt_s;
						volt_t_q <= volt_t;
						fault_q  <= fault_in;
						nph_q    <= nph_now;
						p_q      <= '0;
						ok_cnt_q <= '0;
						over_q   <= 1'b0;
						if (count_q < spb_q) begin
							state_q <= S_ACC;
						end else if (nph_now == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DLD;
						end
					end
				end
				S_ACC: begin
					if (p_q != nph_q) begin
						sums_q[pidx] <= add_sum;
						p_q          <= p_q + 2'd1;
					end else begin
						count_q <= count_q + 16'd1;
						res_q   <= fault_q;
						state_q <= S_DONE;
					end
				end
				S_DLD: begin
					quo_q     <= sums_q[pidx];
					rem_q     <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q     <= rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
					quo_q     <= {quo_q[SUM_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == '1) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					sums_q[pidx]     <= '0;
					valid_q[wr_addr] <= 1'b1;
					if ((avg <= limit_q) && fault_q) begin
						ok_cnt_q <= ok_cnt_q + 2'd1;
					end
					acc_q    <= '0;
					rd_idx_q <= '0;
					state_q  <= S_SUM;
				end
				S_SUM: begin
					if (rd_idx_q != RD_N) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_live_q) begin
						acc_q <= add_sum[ACC_W-1:0];
						// last slot arrives once every read has been issued
						if (rd_idx_q == RD_N) begin
							if (add_sum[ACC_W-1:0] > thr_q) begin
								over_q <= 1'b1;
							end
							p_q <= p_q + 2'd1;
							if ((p_q + 2'd1) == nph_q) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_DLD;
							end
						end
					end
				end
				S_FIN: begin
					count_q <= '0;
					if (clear_cond) begin
						// drop every ring back to the nominal voltage
						valid_q   <= '0;
						clr_nom_q <= nominal_q;
						for (int i = 0; i < PHASES; i++) begin
							sums_q[i] <= '0;
						end
						slot_q <= '0;
						res_q  <= 1'b0;
					end else begin
						slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
						res_q  <= over_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						fault_out_q <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "grid_ten_minute_overvolt_guard_top_macros.svh"

	`GTMOG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`GTMOG_ASSERT_NOW(a_slot_range, 1'b1, slot_q <= SLOT_LAST, "slot pointer out of range")
	`GTMOG_ASSERT_NOW(a_ok_bound, 1'b1, ok_cnt_q <= nph_q, "ok count above phase count")
	`GTMOG_ASSERT_NEXT(a_clear_state, (state_q == S_FIN) && clear_cond, (count_q == '0) && (valid_q == '0) && (slot_q == '0), "clear incomplete")

endmodule

// ----- sim/overvolt_guard_checker.sv -----
// Checker for the ten-minute overvoltage guard: watches the sample and fault channels
// and the register port, predicts each fault flag and compares it. Depends on gtmog_pkg.
`timescale 1ns / 1ps

module overvolt_guard_checker
	import gtmog_pkg::*;
#(
	parameter int unsigned RING_SLOTS = DEF_RING_SLOTS,
	parameter int unsigned PHASES     = DEF_PHASES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [SAMPLE_W-1:0] volt_r,
	input  logic [SAMPLE_W-1:0] volt_s,
	input  logic [SAMPLE_W-1:0] volt_t,
	input  logic                fault_in,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                fault_out,
	output int unsigned         fail_count,
	output int unsigned         pending
);

	logic [SAMPLE_W-1:0]  lim_q;
	logic [PH_W-1:0]      nph_q;
	logic [BLK_CNT_W-1:0] spb_q;
	logic [SAMPLE_W-1:0]  nom_q;

	logic [SUM_W-1:0]     sums [PHASES];
	logic [BLK_CNT_W-1:0] cnt;
	logic [4:0]           slot_q;
	logic [SAMPLE_W-1:0]  ring [PHASES][RING_SLOTS];

	logic fault_due [$];
	logic want;

	function automatic void clear_rings();
		for (int p = 0; p < PHASES; p++) begin
			for (int s = 0; s < RING_SLOTS; s++)
				ring[p][s] = nom_q;
			sums[p] = '0;
		end
		slot_q = '0;
		cnt = '0;
	endfunction

	function automatic logic predict_fault(input logic [SAMPLE_W-1:0] vr, vs, vt,
			input logic flt);
		logic [SAMPLE_W-1:0] v [3];
		logic [SAMPLE_W-1:0] avg;
		logic [SAMPLE_W-1:0] mean [3];
		logic [SUM_W-1:0]    quot;
		logic [SUM_W-1:0]    acc;
		int unsigned         n;
		int unsigned         settled;
		int unsigned         slot;
		logic                over;
		v[0] = vr;
		v[1] = vs;
		v[2] = vt;
		n = (nph_q > PHASES) ? PHASES : nph_q;
		settled = 0;
		over = 1'b0;
		if (cnt < spb_q) begin
			for (int p = 0; p < n; p++)
				sums[p] = sums[p] + v[p];
			cnt = cnt + 1'b1;
			return flt;
		end
		// boundary transaction: its samples are dropped
		if (slot_q >= RING_SLOTS)
			slot_q = '0;
		slot = slot_q;
		for (int p = 0; p < n; p++) begin
			quot = (cnt != 0) ? sums[p] / cnt : '0;
			avg = quot[SAMPLE_W-1:0];
			ring[p][slot] = avg;
			sums[p] = '0;
			acc = '0;
			for (int s = 0; s < RING_SLOTS; s++)
				acc = acc + ring[p][s];
			quot = acc / RING_SLOTS;
			mean[p] = quot[SAMPLE_W-1:0];
			if (avg <= lim_q && flt)
				settled++;
		end
		if (n > 0 && settled >= n) begin
			clear_rings();
			return 1'b0;
		end
		cnt = '0;
		slot_q = (slot + 1 >= RING_SLOTS) ? '0 : 5'(slot + 1);
		for (int p = 0; p < n; p++)
			if (mean[p] > lim_q)
				over = 1'b1;
		return over;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q = RST_LIMIT;
			nph_q = RST_PHASES;
			spb_q = RST_SPB;
			nom_q = RST_NOMINAL;
			clear_rings();
			fault_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// compare before pushing: a result never belongs to the same-edge transaction
			if (out_valid && out_ready) begin
				if (fault_due.size() == 0) begin
					$error("fault_out: result with no transaction pending, actual %0b",
						fault_out);
					fail_count++;
				end else begin
					want = fault_due.pop_front();
					if (want !== fault_out) begin
						$error("fault_out: expected %0b, actual %0b", want, fault_out);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				fault_due.push_back(predict_fault(volt_r, volt_s, volt_t, fault_in));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_LIMIT:   lim_q = pwdata[SAMPLE_W-1:0];
					REG_PHASES:  nph_q = pwdata[PH_W-1:0];
					REG_SPB:     spb_q = pwdata[BLK_CNT_W-1:0];
					REG_NOMINAL: nom_q = pwdata[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			pending <= fault_due.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the overvoltage guard testbench: clock, reset, register writes, sample stimulus
// and verdict. Depends on gtmog_pkg, the guard top level and overvolt_guard_checker.
`timescale 1ns / 1ps

module testbench;
	import gtmog_pkg::*;

	localparam int unsigned WATCHDOG  = 4000;
	localparam int unsigned HOLD_OFF  = 400;
	localparam int unsigned PHASE_CNT = 10;
	localparam int unsigned PER_PHASE = 125;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] volt_r = '0;
	logic [SAMPLE_W-1:0] volt_s = '0;
	logic [SAMPLE_W-1:0] volt_t = '0;
	logic                fault_in = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                fault_out;

	logic        calm = 1'b0;
	logic        squeeze_req = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned quiet = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	grid_ten_minute_overvolt_guard_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.volt_r(volt_r), .volt_s(volt_s), .volt_t(volt_t), .fault_in(fault_in),
		.out_valid(out_valid), .out_ready(out_ready), .fault_out(fault_out)
	);

	overvolt_guard_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.volt_r(volt_r), .volt_s(volt_s), .volt_t(volt_t), .fault_in(fault_in),
		.out_valid(out_valid), .out_ready(out_ready), .fault_out(fault_out),
		.fail_count(fail_count), .pending(pending)
	);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		logic squeezed;
		squeezed = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 26);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [SAMPLE_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DW-SAMPLE_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic [SAMPLE_W-1:0] r, s, t, input logic f);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		volt_r <= r;
		volt_s <= s;
		volt_t <= t;
		fault_in <= f;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and wait until every result is back and the block is free
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0 || !in_ready);
	endtask

	function automatic logic [SAMPLE_W-1:0] near_volt(input int center);
		int v;
		if ($urandom_range(99) < 15)
			return SAMPLE_W'($urandom);
		v = center + int'($urandom_range(0, 800)) - 400;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[SAMPLE_W-1:0];
	endfunction

	initial begin
		logic [SAMPLE_W-1:0]  lim;
		logic [SAMPLE_W-1:0]  nom;
		logic [BLK_CNT_W-1:0] spb;
		logic [PH_W-1:0]      nph;
		int                   bias;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a long block, so these only accumulate
		send_item(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
		send_item(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		send_item(16'h1234, 16'h8001, 16'h7FFE, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'd1000);
		write_reg(REG_PHASES, 16'd3);
		write_reg(REG_SPB, 16'd2);
		write_reg(REG_NOMINAL, 16'hFFFF);
		// count already past the shorter block: boundary at once
		send_item(16'd0, 16'd0, 16'd0, 1'b0);
		// active fault with all averages within the limit: clear
		send_item(16'd900, 16'd900, 16'd900, 1'b1);
		send_item(16'd950, 16'd950, 16'd950, 1'b1);
		send_item(16'd7, 16'd7, 16'd7, 1'b1);
		// active fault, averages far above: no clear
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(16'd0, 16'd0, 16'd0, 1'b1);
		// one phase above the limit blocks the clear
		send_item(16'd500, 16'd500, 16'd5000, 1'b1);
		send_item(16'd500, 16'd500, 16'd5000, 1'b1);
		send_item(16'd0, 16'd0, 16'd0, 1'b1);
		wait_idle();
		write_reg(REG_PHASES, 16'd0);
		send_item(16'd1, 16'd2, 16'd3, 1'b1);
		send_item(16'd4, 16'd5, 16'd6, 1'b1);
		send_item(16'd7, 16'd8, 16'd9, 1'b1);
		wait_idle();
		// zero block length: every transaction is a boundary with a zero average
		write_reg(REG_PHASES, 16'd1);
		write_reg(REG_SPB, 16'd0);
		send_item(16'd1, 16'd1, 16'd1, 1'b1);
		send_item(16'd2, 16'd2, 16'd2, 1'b0);
		send_item(16'd3, 16'd3, 16'd3, 1'b0);
		wait_idle();
		write_reg(REG_LIMIT, 16'hFFFF);
		write_reg(REG_NOMINAL, 16'd0);
		write_reg(REG_PHASES, 16'd2);
		write_reg(REG_SPB, 16'hFFFF);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		wait_idle();
		write_reg(REG_SPB, 16'd1);
		send_item(16'd0, 16'd0, 16'd0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < PHASE_CNT; ph++) begin
			lim = (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF :
				(SAMPLE_W'($urandom_range(1800, 3200)));
			nph = (ph == 2) ? 2'd0 : PH_W'($urandom_range(1, 3));
			spb = (ph == 3) ? 16'd0 : (ph == 8) ? BLK_CNT_W'($urandom_range(20, 60)) :
				BLK_CNT_W'($urandom_range(1, 8));
			nom = (ph == 4) ? 16'd0 : (ph == 5) ? 16'hFFFF :
				near_volt(int'(lim));
			write_reg(REG_LIMIT, lim);
			write_reg(REG_PHASES, SAMPLE_W'(nph));
			write_reg(REG_SPB, spb);
			write_reg(REG_NOMINAL, nom);
			calm <= (ph == 6);
			squeeze_req <= (ph == 7);
			bias = 0;
			for (int k = 0; k < PER_PHASE; k++) begin
				// shift the level now and then so blocks land on both sides of the limit
				if (k % 6 == 0)
					bias = int'($urandom_range(0, 900)) - 700;
				send_item(near_volt(int'(lim) + bias), near_volt(int'(lim) + bias),
					near_volt(int'(lim) + bias), 1'($urandom_range(1)));
			end
			wait_idle();
		end

		calm <= 1'b0;
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gtmog_pkg.sv
rtl/grid_ten_minute_overvolt_guard_top.sv
sim/overvolt_guard_checker.sv
sim/testbench.sv
